// ----- design/lscd_pkg.sv -----
`default_nettype none
package lscd_pkg;

    // Built geometry of the directory.
    localparam int MaxSets     = 64;
    localparam int MaxWays     = 8;
    localparam int AddrBits    = 32;
    localparam int SetBits     = $clog2(MaxSets);
    localparam int AgeBits     = 3;
    localparam int WayCntBits  = 4;
    localparam int PaddrBits   = 4;

    // Register indexes on the configuration port.
    localparam logic [1:0] RegLineSize = 2'd0;
    localparam logic [1:0] RegSetCount = 2'd1;
    localparam logic [1:0] RegWays     = 2'd2;

    // Reset values of the registers.
    localparam logic [3:0] LineSizeReset = 4'd5;
    localparam logic [2:0] SetCountReset = 3'd4;
    localparam logic [3:0] WaysReset     = 4'd4;

    // Request codes.
    localparam logic ReqProbe  = 1'b0;
    localparam logic ReqInsert = 1'b1;

    typedef struct packed {
        logic                req_type;
        logic [AddrBits-1:0] address;
    } req_t;

    typedef struct packed {
        logic         hit;
        logic         would_evict;
        logic [5:0]   set_index;
    } rsp_t;

endpackage
`default_nettype wire

// ----- design/lru_set_assoc_cache_directory_unit.sv -----
`default_nettype none
// Set-associative cache directory with LRU replacement. Each item is a probe or an
// insert of one byte address; it returns hit, would_evict and the selected set. One
// item is handled in two steps: the set's row is read from the directory memory on
// accept; then all ways are evaluated and, for an insert, the updated row is written
// back. Only one item is in flight, so the read and write of a row never overlap.
// Reset and any configuration write that changes a register value flush the directory
// at once through one valid flag per set; no clearing pass is needed.
module lru_set_assoc_cache_directory_unit
    import lscd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire req_t                 in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output rsp_t                      out_data,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [PaddrBits-1:0] paddr,
    input  wire logic [31:0]          pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    typedef enum logic {ST_IDLE, ST_LOOK} state_t;

    typedef logic [MaxWays-1:0][AddrBits-1:0] addr_row_t;
    typedef logic [MaxWays-1:0][AgeBits-1:0]  age_row_t;

    state_t                 state_reg;
    logic                   out_valid_reg;
    rsp_t                   out_data_reg;
    req_t                   req_reg;
    logic [SetBits-1:0]     set_reg;
    logic [MaxSets-1:0]     row_valid_reg;
    logic [3:0]             line_size_reg;
    logic [2:0]             set_count_reg;
    logic [3:0]             ways_reg;

    // Directory memories: one row per set.
    addr_row_t              mem_addr [MaxSets];
    logic [MaxWays-1:0]     mem_vld  [MaxSets];
    age_row_t               mem_age  [MaxSets];
    addr_row_t              rd_addr_reg;
    logic [MaxWays-1:0]     rd_vld_reg;
    age_row_t               rd_age_reg;

    logic                   in_fire;
    logic                   go;
    logic                   cfg_wr;
    logic [SetBits-1:0]     set_calc;
    logic [2:0]             set_log2_eff;
    logic [WayCntBits-1:0]  ways_eff;
    logic [AddrBits-1:0]    line_num;
    logic [MaxWays-1:0]     way_use;
    logic [MaxWays-1:0]     cur_vld;
    logic [MaxWays-1:0]     vld_next;
    age_row_t               age_next;
    addr_row_t              addr_next;
    logic [WayCntBits-1:0]  vcount;
    logic                   full;
    logic                   hit_found;
    logic [2:0]             hit_way;
    logic [AgeBits-1:0]     hit_age;
    logic                   old_found;
    logic [2:0]             old_way;
    logic [AgeBits-1:0]     old_age;
    logic                   free_found;
    logic [2:0]             free_way;
    logic [2:0]             tgt_way;
    logic [3:0]             cfg_mask_val;
    logic                   cfg_change;

    assign pready    = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign go        = (state_reg == ST_LOOK) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign cfg_wr    = psel && penable && pwrite;

    // Effective geometry from the registers.
    always_comb
    begin
        set_log2_eff = (set_count_reg > 3'(SetBits)) ? 3'(SetBits) : set_count_reg;
        if (ways_reg == '0)
            ways_eff = 4'd1;
        else if (ways_reg > 4'(MaxWays))
            ways_eff = 4'(MaxWays);
        else
            ways_eff = ways_reg;
        line_num = in_data.address >> line_size_reg;
        set_calc = line_num[SetBits-1:0] & SetBits'((7'd1 << set_log2_eff) - 7'd1);
    end

    // Configuration write decode and read data.
    always_comb
    begin
        cfg_mask_val = '0;
        cfg_change   = 1'b0;
        prdata       = '0;
        case (paddr[3:2])
            RegLineSize:
            begin
                cfg_mask_val = pwdata[3:0];
                cfg_change   = cfg_mask_val != line_size_reg;
                prdata       = {28'd0, line_size_reg};
            end
            RegSetCount:
            begin
                cfg_mask_val = {1'b0, pwdata[2:0]};
                cfg_change   = cfg_mask_val[2:0] != set_count_reg;
                prdata       = {29'd0, set_count_reg};
            end
            RegWays:
            begin
                cfg_mask_val = pwdata[3:0];
                cfg_change   = cfg_mask_val != ways_reg;
                prdata       = {28'd0, ways_reg};
            end
            default:
            begin
                cfg_mask_val = '0;
                cfg_change   = 1'b0;
                prdata       = '0;
            end
        endcase
    end

    // Evaluate the row read for the current item and build its update.
    always_comb
    begin
        for (int w = 0; w < MaxWays; w++)
        begin
            way_use[w] = 4'(w) < ways_eff;
        end
        cur_vld    = row_valid_reg[set_reg] ? rd_vld_reg : '0;
        vcount     = '0;
        hit_found  = 1'b0;
        hit_way    = '0;
        old_found  = 1'b0;
        old_way    = '0;
        old_age    = '0;
        free_found = 1'b0;
        free_way   = '0;
        for (int w = 0; w < MaxWays; w++)
        begin
            if (way_use[w] && cur_vld[w])
            begin
                vcount = vcount + 4'd1;
                if (!hit_found && rd_addr_reg[w] == req_reg.address)
                begin
                    hit_found = 1'b1;
                    hit_way   = 3'(w);
                end
                if (!old_found || rd_age_reg[w] > old_age)
                begin
                    old_found = 1'b1;
                    old_age   = rd_age_reg[w];
                    old_way   = 3'(w);
                end
            end
            if (way_use[w] && !cur_vld[w] && !free_found)
            begin
                free_found = 1'b1;
                free_way   = 3'(w);
            end
        end
        full    = vcount >= ways_eff;
        hit_age = rd_age_reg[hit_way];
        tgt_way = full ? old_way : free_way;

        vld_next  = cur_vld;
        addr_next = rd_addr_reg;
        for (int w = 0; w < MaxWays; w++)
        begin
            age_next[w] = row_valid_reg[set_reg] ? rd_age_reg[w] : '0;
        end
        if (hit_found)
        begin
            // Hit: ways younger than the hit way age by one, hit becomes MRU.
            for (int w = 0; w < MaxWays; w++)
            begin
                if (way_use[w] && cur_vld[w] && rd_age_reg[w] < hit_age)
                    age_next[w] = rd_age_reg[w] + 3'd1;
            end
            age_next[hit_way] = '0;
        end
        else
        begin
            // Miss: every other valid way ages, the target takes the address at MRU.
            for (int w = 0; w < MaxWays; w++)
            begin
                if (way_use[w] && cur_vld[w] && 3'(w) != tgt_way)
                    age_next[w] = age_next[w] + 3'd1;
            end
            vld_next[tgt_way]  = 1'b1;
            age_next[tgt_way]  = '0;
            addr_next[tgt_way] = req_reg.address;
        end
    end

    // Control state, registers and result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            row_valid_reg <= '0;
            line_size_reg <= LineSizeReset;
            set_count_reg <= SetCountReset;
            ways_reg      <= WaysReset;
        end
        else
        begin
            // A finished lookup loads the result; otherwise an accepted result clears it.
            if (go)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                        state_reg <= ST_LOOK;
                end
                ST_LOOK:
                begin
                    if (go)
                        state_reg <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
            // A change of geometry flushes the whole directory.
            if (cfg_wr && cfg_change)
            begin
                row_valid_reg <= '0;
                case (paddr[3:2])
                    RegLineSize: line_size_reg <= cfg_mask_val;
                    RegSetCount: set_count_reg <= cfg_mask_val[2:0];
                    RegWays:     ways_reg      <= cfg_mask_val;
                    default:     ways_reg      <= ways_reg;
                endcase
            end
            else if (go && req_reg.req_type == ReqInsert)
                row_valid_reg[set_reg] <= 1'b1;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            req_reg <= in_data;
            set_reg <= set_calc;
        end
        if (go)
        begin
            out_data_reg.hit         <= hit_found;
            out_data_reg.would_evict <= !hit_found && full;
            out_data_reg.set_index   <= 6'(set_reg);
        end
    end

    // Directory memory: read on accept, write back after evaluation of an insert.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            rd_addr_reg <= mem_addr[set_calc];
            rd_vld_reg  <= mem_vld[set_calc];
            rd_age_reg  <= mem_age[set_calc];
        end
        if (go && req_reg.req_type == ReqInsert)
        begin
            mem_addr[set_reg] <= addr_next;
            mem_vld[set_reg]  <= vld_next;
            mem_age[set_reg]  <= age_next;
        end
    end

endmodule
`default_nettype wire

// ----- design/lscd_checker.sv -----
`default_nettype none
module lscd_checker
    import lscd_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_ready,
    input wire logic out_valid,
    input wire logic out_ready,
    input wire rsp_t out_data,
    input wire logic pready
);

    // A result never reports a hit and an eviction together.
    a_hit_evict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.hit && out_data.would_evict))
        else $error("hit and would_evict both set");

    // A stalled result keeps its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // After an item is taken the block is busy for its lookup.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("item accepted during lookup");

    // A result appears only after an item was taken.
    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result without item");

    // The configuration port never waits.
    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind lru_set_assoc_cache_directory_unit lscd_checker u_lscd_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data), .pready(pready)
);
`default_nettype wire

// ----- bench/lru_set_assoc_cache_directory_checker.sv -----
`timescale 1ns / 100ps
`default_nettype none
module lru_set_assoc_cache_directory_checker
    import lscd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic                 in_ready,
    input  wire req_t                 in_data,
    input  wire logic                 out_valid,
    input  wire logic                 out_ready,
    input  wire rsp_t                 out_data,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic                 pready,
    input  wire logic [PaddrBits-1:0] paddr,
    input  wire logic [31:0]          pwdata,
    output int                        fail_count,
    output int                        pending_count,
    output int                        lookup_count,
    output int                        hit_count,
    output int                        evict_count
);

    // Shadow copy of the directory and its registers.
    logic [AddrBits-1:0] dir_addr [MaxSets][MaxWays];
    logic                dir_valid [MaxSets][MaxWays];
    logic [AgeBits-1:0]  dir_age [MaxSets][MaxWays];
    logic [3:0]          line_log2;
    logic [2:0]          sets_log2;
    logic [3:0]          ways_reg;
    rsp_t                expected_rsp [$];

    function automatic void clear_directory();
        for (int s = 0; s < MaxSets; s++)
            for (int w = 0; w < MaxWays; w++)
            begin
                dir_valid[s][w] = 1'b0;
                dir_age[s][w]   = '0;
            end
    endfunction

    // Looks up one request, updates the shadow state on insert and returns the response.
    function automatic rsp_t lookup_and_update(req_t req);
        rsp_t r;
        int   s_log2;
        int   set;
        int   ways;
        int   count;
        int   hit_way;
        int   target;
        logic [AgeBits-1:0] old_age;
        logic full;
        s_log2 = sets_log2;
        while (s_log2 > 0 && (1 << s_log2) > MaxSets) s_log2--;
        set = int'((req.address >> line_log2) & ((32'd1 << s_log2) - 1));
        ways = (ways_reg == 0) ? 1 : (ways_reg > MaxWays ? MaxWays : ways_reg);
        count = 0;
        hit_way = -1;
        for (int w = 0; w < ways; w++)
        begin
            if (dir_valid[set][w])
            begin
                count++;
                if (hit_way < 0 && dir_addr[set][w] == req.address) hit_way = w;
            end
        end
        full = (count >= ways);
        r.hit = (hit_way >= 0);
        r.would_evict = (hit_way < 0) && full;
        r.set_index = set[5:0];
        if (req.req_type == ReqInsert)
        begin
            if (hit_way >= 0)
            begin
                old_age = dir_age[set][hit_way];
                for (int w = 0; w < ways; w++)
                    if (dir_valid[set][w] && dir_age[set][w] < old_age)
                        dir_age[set][w]++;
                dir_age[set][hit_way] = '0;
            end
            else
            begin
                target = -1;
                if (full)
                begin
                    old_age = '0;
                    for (int w = 0; w < ways; w++)
                        if (dir_valid[set][w] && (target < 0 || dir_age[set][w] > old_age))
                        begin
                            old_age = dir_age[set][w];
                            target = w;
                        end
                end
                else
                begin
                    for (int w = ways - 1; w >= 0; w--)
                        if (!dir_valid[set][w]) target = w;
                end
                if (target < 0) target = 0;
                dir_valid[set][target] = 1'b0;
                for (int w = 0; w < ways; w++)
                    if (dir_valid[set][w]) dir_age[set][w]++;
                dir_valid[set][target] = 1'b1;
                dir_age[set][target] = '0;
                dir_addr[set][target] = req.address;
            end
        end
        return r;
    endfunction

    // Register writes, returned items and accepted items, in event order of one edge.
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t exp_rsp;
        logic [3:0] value;
        if (!rst_n)
        begin
            line_log2 = LineSizeReset;
            sets_log2 = SetCountReset;
            ways_reg  = WaysReset;
            clear_directory();
            expected_rsp.delete();
            fail_count = 0;
            pending_count = 0;
            lookup_count = 0;
            hit_count = 0;
            evict_count = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                value = pwdata[3:0];
                if (paddr[3:2] == RegLineSize && line_log2 != value)
                begin
                    line_log2 = value;
                    clear_directory();
                end
                else if (paddr[3:2] == RegSetCount && sets_log2 != value[2:0])
                begin
                    sets_log2 = value[2:0];
                    clear_directory();
                end
                else if (paddr[3:2] == RegWays && ways_reg != value)
                begin
                    ways_reg = value;
                    clear_directory();
                end
            end
            if (out_valid && out_ready)
            begin
                if (expected_rsp.size() == 0)
                begin
                    $display("%0t: unexpected item, actual %p", $time, out_data);
                    fail_count++;
                end
                else
                begin
                    exp_rsp = expected_rsp.pop_front();
                    if (out_data.hit !== exp_rsp.hit)
                    begin
                        $display("%0t: hit expected %b actual %b",
                                 $time, exp_rsp.hit, out_data.hit);
                        fail_count++;
                    end
                    if (out_data.would_evict !== exp_rsp.would_evict)
                    begin
                        $display("%0t: would_evict expected %b actual %b",
                                 $time, exp_rsp.would_evict, out_data.would_evict);
                        fail_count++;
                    end
                    if (out_data.set_index !== exp_rsp.set_index)
                    begin
                        $display("%0t: set_index expected %0d actual %0d",
                                 $time, exp_rsp.set_index, out_data.set_index);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                exp_rsp = lookup_and_update(in_data);
                expected_rsp.push_back(exp_rsp);
                lookup_count++;
                if (exp_rsp.hit) hit_count++;
                if (exp_rsp.would_evict) evict_count++;
            end
            pending_count = expected_rsp.size();
        end
    end

endmodule
`default_nettype wire

// ----- bench/lru_set_assoc_cache_directory_unit_test.sv -----
`timescale 1ns / 100ps
`default_nettype none
module lru_set_assoc_cache_directory_unit_test;
    import lscd_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    req_t                 in_data;
    logic                 out_valid;
    logic                 out_ready;
    rsp_t                 out_data;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PaddrBits-1:0] paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;
    int                   fail_count;
    int                   pending_count;
    int                   lookup_count;
    int                   hit_count;
    int                   evict_count;
    logic                 calm_phase;
    logic                 hold_off;
    logic [AddrBits-1:0]  recent_addr [16];

    lru_set_assoc_cache_directory_unit u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    lru_set_assoc_cache_directory_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .fail_count(fail_count), .pending_count(pending_count),
        .lookup_count(lookup_count), .hit_count(hit_count), .evict_count(evict_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Receiver: random stall bursts, or a long hold-off on request.
    initial
    begin
        int burst;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                out_ready <= 1'b0;
                for (int i = 0; i < 60; i++) @(posedge clk);
                out_ready <= 1'b1;
                hold_off = 1'b0;
            end
            else if (!calm_phase && $urandom_range(0, 5) == 0)
            begin
                burst = $urandom_range(1, 4);
                out_ready <= 1'b0;
                for (int i = 1; i < burst; i++) @(posedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // One configuration write: setup cycle, then access cycle.
    task automatic write_register(input logic [1:0] index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Present one item, with an optional idle burst before it.
    task automatic send_lookup(input logic kind, input logic [AddrBits-1:0] addr);
        int gap;
        if (!calm_phase && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 4);
            in_valid <= 1'b0;
            for (int i = 0; i < gap; i++) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{req_type: kind, address: addr};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        recent_addr[$urandom_range(0, 15)] = addr;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Random item: reuse of recent addresses, small shifted addresses, and some wild ones.
    task automatic send_random_lookup();
        logic [AddrBits-1:0] addr;
        logic                kind;
        int                  pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            addr = recent_addr[$urandom_range(0, 15)];
        else if (pick < 9)
            addr = $urandom_range(0, 2047) << $urandom_range(0, 5);
        else
            addr = $urandom;
        kind = ($urandom_range(0, 2) != 0) ? ReqInsert : ReqProbe;
        send_lookup(kind, addr);
    endtask

    initial
    begin
        logic [31:0] geometry [6][3];
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        calm_phase = 1'b0;
        hold_off = 1'b0;
        for (int i = 0; i < 16; i++) recent_addr[i] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under reset geometry: fill one set past its ways,
        // hit, re-touch and evict, plus address extremes.
        send_lookup(ReqProbe, 32'h0000_0000);
        send_lookup(ReqInsert, 32'h0000_0000);
        send_lookup(ReqProbe, 32'h0000_0000);
        send_lookup(ReqProbe, 32'h0000_0001);
        for (int i = 1; i < 5; i++) send_lookup(ReqInsert, i << 9);
        send_lookup(ReqProbe, 32'h0000_0000);
        send_lookup(ReqInsert, 32'h0000_0200);
        send_lookup(ReqInsert, 32'h0000_0000);
        send_lookup(ReqProbe, 32'h0000_0400);
        send_lookup(ReqInsert, 32'hFFFF_FFFF);
        send_lookup(ReqProbe, 32'hFFFF_FFFF);
        send_lookup(ReqInsert, 32'hAAAA_AAAA);
        send_lookup(ReqInsert, 32'h5555_5555);
        send_lookup(ReqProbe, 32'h5555_5555);
        wait_idle();

        // Geometry settings: extremes, out of range values and a zero way count.
        geometry = '{'{0, 0, 1}, '{12, 6, 8}, '{15, 7, 0}, '{3, 2, 15},
                     '{5, 4, 4}, '{1, 1, 2}};
        for (int g = 0; g < 6; g++)
        begin
            write_register(RegLineSize, geometry[g][0]);
            write_register(RegSetCount, geometry[g][1]);
            write_register(RegWays, geometry[g][2]);
            // An index past the register list is ignored.
            if (g == 2) write_register(2'd3, 32'h7);
            @(posedge clk);
            if (g == 1) hold_off = 1'b1;
            if (g == 5) calm_phase = 1'b1;
            for (int i = 0; i < 75; i++) send_random_lookup();
            wait_idle();
        end

        $display("Covered %0d lookups over six geometries: %0d hits, %0d full-set misses.",
                 lookup_count, hit_count, evict_count);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
`default_nettype wire
